// ===== rtl/swfd_pkg.sv =====
// ----------------------------------------------------------------------------
// swfd_pkg
// Types, codes and the known-tag lookup shared by the tag record deframer.
// ----------------------------------------------------------------------------
package swfd_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_HDR_LO  = 2'd0,
    PH_HDR_HI  = 2'd1,
    PH_LONGLEN = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_e;

  localparam logic [5:0] LONG_LEN_MARK = 6'h3F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_stream;
  } in_item_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [9:0]  tag_id;
    logic [31:0] tag_length;
    logic [3:0]  tag_class;
    logic [7:0]  payload_byte;
    logic        last_of_tag;
    logic        truncated;
  } out_item_t;

  // Classified byte handed from the front part to the back part
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        restart;
    logic        active;
    logic        rem_zero;
    logic [31:0] remaining;
  } cmd_t;

  function automatic logic [3:0] tag_class_of(input logic [9:0] id);
    logic [3:0] cls;
    cls = 4'd0;
    unique case (id)
      10'd0:   cls = 4'd1;
      10'd1:   cls = 4'd2;
      10'd9:   cls = 4'd3;
      10'd69:  cls = 4'd4;
      10'd73:  cls = 4'd5;
      10'd75:  cls = 4'd6;
      10'd76:  cls = 4'd7;
      10'd82:  cls = 4'd8;
      10'd86:  cls = 4'd9;
      10'd88:  cls = 4'd10;
      default: cls = 4'd0;
    endcase
    return cls;
  endfunction

endpackage

// ===== rtl/swfd_front.sv =====
// ----------------------------------------------------------------------------
// swfd_front
// Accepts bytes, tracks the stream position and classifies each byte
// against the configured stream length.
// ----------------------------------------------------------------------------
module swfd_front import swfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output cmd_t        push_data_o
);

  logic [31:0] stream_len_q, stream_len_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] pos_eff;
  logic        active;
  logic        accept;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  always_comb begin
    pos_eff = in_data_i.first_of_stream ? 32'd0 : pos_q;
    active  = pos_eff < stream_len_q;

    push_data_o.data_byte = in_data_i.data_byte;
    push_data_o.restart   = in_data_i.first_of_stream;
    push_data_o.active    = active;
    push_data_o.remaining = stream_len_q - pos_eff - 32'd1;
    push_data_o.rem_zero  = (pos_eff + 32'd1) == stream_len_q;

    stream_len_d = cfg_valid_i ? cfg_data_i : stream_len_q;
    pos_d        = pos_q;
    if (accept) begin
      pos_d = active ? pos_eff + 32'd1 : pos_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_len_q <= 32'hFFFF_FFFF;
      pos_q        <= 32'd0;
    end else begin
      stream_len_q <= stream_len_d;
      pos_q        <= pos_d;
    end
  end

endmodule

// ===== rtl/swfd_queue.sv =====
// ----------------------------------------------------------------------------
// swfd_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module swfd_queue import swfd_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = count_q != FullCnt;
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/swfd_back.sv =====
// ----------------------------------------------------------------------------
// swfd_back
// Runs the record header state machine on classified bytes and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module swfd_back import swfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  cmd_t      pop_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  phase_e      phase_q, phase_d, phase_eff;
  logic [7:0]  hdr_lo_q, hdr_lo_d;
  logic [9:0]  tag_id_q, tag_id_d;
  logic [3:0]  class_q, class_d;
  logic [31:0] accum_q, accum_d, accum_eff, accum_new;
  logic [1:0]  cnt_q, cnt_d, cnt_eff;
  logic [31:0] pay_rem_q, pay_rem_d, pay_rem_eff;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic        take;
  logic        hdr_go;
  logic [31:0] hdr_len, clamp_len;
  logic        clamp;
  logic [15:0] hdr;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign take        = pop_valid_i && pop_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    phase_d     = phase_q;
    hdr_lo_d    = hdr_lo_q;
    tag_id_d    = tag_id_q;
    class_d     = class_q;
    accum_d     = accum_q;
    cnt_d       = cnt_q;
    pay_rem_d   = pay_rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    hdr_go      = 1'b0;
    hdr_len     = 32'd0;
    hdr         = {pop_data_i.data_byte, hdr_lo_q};
    accum_new   = 32'd0;

    phase_eff   = pop_data_i.restart ? PH_HDR_LO : phase_q;
    accum_eff   = pop_data_i.restart ? 32'd0 : accum_q;
    cnt_eff     = pop_data_i.restart ? 2'd0 : cnt_q;
    pay_rem_eff = pop_data_i.restart ? 32'd0 : pay_rem_q;

    if (take) begin
      phase_d   = phase_eff;
      accum_d   = accum_eff;
      cnt_d     = cnt_eff;
      pay_rem_d = pay_rem_eff;

      if (pop_data_i.active) begin
        if (phase_eff == PH_PAYLOAD && pay_rem_eff == 32'd0) begin
          phase_eff = PH_HDR_LO;
        end
        out_d = '0;

        unique case (phase_eff)
          PH_HDR_HI: begin
            tag_id_d = hdr[15:6];
            class_d  = tag_class_of(hdr[15:6]);
            if (hdr[5:0] == LONG_LEN_MARK) begin
              accum_d = 32'd0;
              cnt_d   = 2'd0;
              phase_d = PH_LONGLEN;
              if (pop_data_i.rem_zero) begin
                out_d.result_kind = KIND_ERROR;
                out_valid_d       = 1'b1;
                phase_d           = PH_HDR_LO;
              end
            end else begin
              hdr_go  = 1'b1;
              hdr_len = {26'd0, hdr[5:0]};
            end
          end
          PH_LONGLEN: begin
            unique case (cnt_eff)
              2'd0: accum_new = accum_eff | {24'd0, pop_data_i.data_byte};
              2'd1: accum_new = accum_eff | {16'd0, pop_data_i.data_byte, 8'd0};
              2'd2: accum_new = accum_eff | {8'd0, pop_data_i.data_byte, 16'd0};
              default: accum_new = accum_eff | {pop_data_i.data_byte, 24'd0};
            endcase
            accum_d = accum_new;
            cnt_d   = cnt_eff + 2'd1;
            if (cnt_eff == 2'd3) begin
              hdr_go  = 1'b1;
              hdr_len = accum_new;
            end else if (pop_data_i.rem_zero) begin
              out_d.result_kind = KIND_ERROR;
              out_valid_d       = 1'b1;
              phase_d           = PH_HDR_LO;
            end
          end
          PH_PAYLOAD: begin
            pay_rem_d          = pay_rem_eff - 32'd1;
            out_d.result_kind  = KIND_PAYLOAD;
            out_d.tag_id       = tag_id_q;
            out_d.tag_class    = class_q;
            out_d.payload_byte = pop_data_i.data_byte;
            out_d.last_of_tag  = pay_rem_eff == 32'd1;
            out_valid_d        = 1'b1;
            phase_d            = (pay_rem_eff == 32'd1) ? PH_HDR_LO : PH_PAYLOAD;
          end
          default: begin
            hdr_lo_d = pop_data_i.data_byte;
            phase_d  = PH_HDR_HI;
            if (pop_data_i.rem_zero) begin
              out_d.result_kind = KIND_ERROR;
              out_valid_d       = 1'b1;
              phase_d           = PH_HDR_LO;
            end
          end
        endcase
      end
    end

    clamp     = hdr_len > pop_data_i.remaining;
    clamp_len = clamp ? pop_data_i.remaining : hdr_len;
    if (hdr_go) begin
      out_d.result_kind = KIND_HEADER;
      out_d.tag_id      = tag_id_d;
      out_d.tag_length  = clamp_len;
      out_d.tag_class   = class_d;
      out_d.last_of_tag = clamp_len == 32'd0;
      out_d.truncated   = clamp;
      out_valid_d       = 1'b1;
      pay_rem_d         = clamp_len;
      phase_d           = (clamp_len == 32'd0) ? PH_HDR_LO : PH_PAYLOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HDR_LO;
      hdr_lo_q    <= 8'd0;
      tag_id_q    <= 10'd0;
      class_q     <= 4'd1;
      accum_q     <= 32'd0;
      cnt_q       <= 2'd0;
      pay_rem_q   <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_lo_q    <= hdr_lo_d;
      tag_id_q    <= tag_id_d;
      class_q     <= class_d;
      accum_q     <= accum_d;
      cnt_q       <= cnt_d;
      pay_rem_q   <= pay_rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ===== rtl/swf_tag_record_deframer.sv =====
// ----------------------------------------------------------------------------
// swf_tag_record_deframer
// Splits the byte stream of an uncompressed tag area into tag records.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle while the queue has room. A front
// stage counts stream position against stream_length and classifies each
// byte; a short queue (QueueDepth entries) feeds the back stage, which walks
// the record header (short or long length form), clamps the length to the
// bytes left, and emits a header result, then each payload byte with the
// last one flagged. A header cut off at stream end yields an error result.
// Each byte gives at most one result. An accepted byte passes through the queue;
// the output register accepts a new result in the cycle its old one is taken,
// so the sustained rate is one byte per cycle with no stall on either side.
// stream_length resets to all ones and is written through the cfg channel,
// which is always ready.
module swf_tag_record_deframer import swfd_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  swfd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output swfd_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);

  logic push_valid, push_ready;
  cmd_t push_data;
  logic pop_valid, pop_ready;
  cmd_t pop_data;

  swfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  swfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  swfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== test/swf_tag_record_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swf_tag_record_deframer_tb
// Self-checking bench for the tag record deframer. A queue-fed driver sends
// tag-area bytes under random gaps while a monitor stalls the result side at
// random. Each accepted request is run through a local deframer model, and
// its results are checked in order against the block's results. Directed
// streams cover the header and stream-end corner cases. Random phases then
// write new stream lengths and send mostly well-formed tag records with some
// raw noise.
// ----------------------------------------------------------------------------
module swf_tag_record_deframer_tb;
  import swfd_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1850;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam logic [9:0]  KNOWN_TAG_IDS [10] = '{10'd0, 10'd1, 10'd9, 10'd69, 10'd73,
                                                 10'd75, 10'd76, 10'd82, 10'd86, 10'd88};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  in_item_t    tag_bytes [$];
  out_item_t   deframed_due [$];
  out_item_t   predicted;
  out_item_t   want;
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_wait = 0;
  int unsigned send_burst = 0;
  int unsigned recv_wait = 0;
  int unsigned recv_burst = 0;

  logic [31:0] stream_limit = 32'hFFFF_FFFF;
  phase_e      walk_phase = PH_HDR_LO;
  logic [7:0]  hdr_lo_q = '0;
  logic [9:0]  cur_id = '0;
  logic [31:0] len_accum = '0;
  logic [1:0]  len_count = '0;
  logic [31:0] bytes_left_in_tag = '0;
  logic [31:0] stream_pos = '0;

  always #2 clk_i = ~clk_i;

  swf_tag_record_deframer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  function automatic logic [3:0] class_for_id(input logic [9:0] id);
    for (int i = 0; i < 10; i++) begin
      if (KNOWN_TAG_IDS[i] == id) return 4'(i + 1);
    end
    return 4'd0;
  endfunction

  function automatic bit cut_header(output out_item_t res);
    res = '0;
    res.result_kind = KIND_ERROR;
    walk_phase = PH_HDR_LO;
    return 1'b1;
  endfunction

  function automatic bit close_header(input logic [31:0] declared,
                                      input logic [31:0] remaining,
                                      output out_item_t res);
    res = '0;
    res.result_kind = KIND_HEADER;
    res.tag_id = cur_id;
    res.tag_class = class_for_id(cur_id);
    res.truncated = declared > remaining;
    res.tag_length = res.truncated ? remaining : declared;
    res.last_of_tag = res.tag_length == 0;
    bytes_left_in_tag = res.tag_length;
    walk_phase = (res.tag_length == 0) ? PH_HDR_LO : PH_PAYLOAD;
    return 1'b1;
  endfunction

  function automatic bit deframe_byte(input in_item_t it, output out_item_t res);
    logic [31:0] remaining;
    logic [15:0] hdr;
    res = '0;
    if (it.first_of_stream) begin
      walk_phase = PH_HDR_LO;
      stream_pos = '0;
      len_accum = '0;
      len_count = '0;
      bytes_left_in_tag = '0;
    end
    if (stream_pos >= stream_limit) return 1'b0;
    stream_pos++;
    remaining = stream_limit - stream_pos;
    if (walk_phase == PH_PAYLOAD && bytes_left_in_tag == 0) walk_phase = PH_HDR_LO;
    case (walk_phase)
      PH_HDR_HI: begin
        hdr = {it.data_byte, hdr_lo_q};
        cur_id = hdr[15:6];
        if (hdr[5:0] == LONG_LEN_MARK) begin
          len_accum = '0;
          len_count = '0;
          walk_phase = PH_LONGLEN;
          if (remaining == 0) return cut_header(res);
          return 1'b0;
        end
        return close_header({26'd0, hdr[5:0]}, remaining, res);
      end
      PH_LONGLEN: begin
        len_accum = len_accum | ({24'd0, it.data_byte} << (8 * len_count));
        len_count++;
        if (len_count == 0) return close_header(len_accum, remaining, res);
        if (remaining == 0) return cut_header(res);
        return 1'b0;
      end
      PH_PAYLOAD: begin
        bytes_left_in_tag--;
        res.result_kind = KIND_PAYLOAD;
        res.tag_id = cur_id;
        res.tag_class = class_for_id(cur_id);
        res.payload_byte = it.data_byte;
        res.last_of_tag = bytes_left_in_tag == 0;
        if (bytes_left_in_tag == 0) walk_phase = PH_HDR_LO;
        return 1'b1;
      end
      default: begin
        hdr_lo_q = it.data_byte;
        walk_phase = PH_HDR_HI;
        if (remaining == 0) return cut_header(res);
        return 1'b0;
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (deframe_byte(in_data_i, predicted)) deframed_due.push_back(predicted);
        accepted_count++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_wait > 0 || tag_bytes.size() == 0) begin
          in_valid_i <= 1'b0;
          if (send_wait > 0) send_wait--;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i <= tag_bytes.pop_front();
          if (send_burst > 0) begin
            send_burst--;
          end else if ($urandom_range(0, 49) == 0) begin
            send_burst = $urandom_range(20, 100);
          end else begin
            send_wait = pick_gap();
          end
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (deframed_due.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: kind=%0d id=%0d len=%0d class=%0d byte=%02h last=%0b trunc=%0b",
                     out_data_o.result_kind, out_data_o.tag_id, out_data_o.tag_length,
                     out_data_o.tag_class, out_data_o.payload_byte, out_data_o.last_of_tag,
                     out_data_o.truncated);
        end else begin
          want = deframed_due.pop_front();
          if (out_data_o.result_kind !== want.result_kind ||
              out_data_o.tag_id !== want.tag_id ||
              out_data_o.tag_length !== want.tag_length ||
              out_data_o.tag_class !== want.tag_class ||
              out_data_o.payload_byte !== want.payload_byte ||
              out_data_o.last_of_tag !== want.last_of_tag ||
              out_data_o.truncated !== want.truncated) begin
            error_count++;
            if (error_count <= 10)
              $display({"mismatch: expected kind=%0d id=%0d len=%0d class=%0d byte=%02h ",
                        "last=%0b trunc=%0b, got kind=%0d id=%0d len=%0d class=%0d ",
                        "byte=%02h last=%0b trunc=%0b"},
                       want.result_kind, want.tag_id, want.tag_length, want.tag_class,
                       want.payload_byte, want.last_of_tag, want.truncated,
                       out_data_o.result_kind, out_data_o.tag_id, out_data_o.tag_length,
                       out_data_o.tag_class, out_data_o.payload_byte, out_data_o.last_of_tag,
                       out_data_o.truncated);
          end
        end
      end
      if (recv_wait > 0) begin
        out_ready_i <= 1'b0;
        recv_wait--;
      end else begin
        out_ready_i <= 1'b1;
        if (recv_burst > 0) begin
          recv_burst--;
        end else if ($urandom_range(0, 49) == 0) begin
          recv_burst = $urandom_range(20, 100);
        end else begin
          recv_wait = pick_gap();
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL swf_tag_record_deframer");
        $finish;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic first);
    in_item_t it;
    it.data_byte = b;
    it.first_of_stream = first;
    tag_bytes.push_back(it);
    queued_count++;
  endtask

  task automatic wait_drained();
    while (accepted_count != queued_count || deframed_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_stream_length(input logic [31:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    stream_limit = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic build_stream(input int unsigned span, input bit restart, input bit noisy);
    logic [7:0]  rec [$];
    logic [9:0]  id;
    logic [31:0] len;
    logic [15:0] hdr;
    int unsigned sent;
    sent = 0;
    while (sent < span) begin
      if (noisy) begin
        queue_byte(8'($urandom_range(0, 255)),
                   (restart && sent == 0) || $urandom_range(0, 15) == 0);
        sent++;
      end else begin
        id = $urandom_range(0, 1) ? KNOWN_TAG_IDS[$urandom_range(0, 9)]
                                  : 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 9) < 3) begin
          case ($urandom_range(0, 9))
            0, 1:    len = $urandom();
            2:       len = $urandom_range(63, 300);
            default: len = $urandom_range(0, 10);
          endcase
          hdr = {id, LONG_LEN_MARK};
          rec = '{hdr[7:0], hdr[15:8], len[7:0], len[15:8], len[23:16], len[31:24]};
        end else begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 62) : $urandom_range(0, 8);
          hdr = {id, len[5:0]};
          rec = '{hdr[7:0], hdr[15:8]};
        end
        for (int unsigned k = 0; k < len && rec.size() < span; k++)
          rec.push_back(8'($urandom_range(0, 255)));
        foreach (rec[k]) begin
          if (sent < span) begin
            queue_byte(rec[k], restart && sent == 0);
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    logic [31:0] limit;
    int unsigned span;
    int unsigned phase_bytes;
    int unsigned streams;
    int unsigned random_done;
    int unsigned phase_no;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // end tag, max id, long form, known ids
    set_stream_length(32'hFFFF_FFFF);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hC2, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h3F, 1'b0);
    queue_byte(8'h16, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hA5, 1'b0);

    // clamp to remaining, then drop bytes past stream end
    set_stream_length(32'd3);
    queue_byte(8'h05, 1'b1);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'h77, 1'b0);

    // header ending at stream end, with and without clamp, and a long-form header cut at stream end
    set_stream_length(32'd2);
    queue_byte(8'h41, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h12, 1'b0);
    queue_byte(8'h3F, 1'b1);
    queue_byte(8'h00, 1'b0);

    // header cut short at stream end
    set_stream_length(32'd1);
    queue_byte(8'h00, 1'b1);
    set_stream_length(32'd4);
    queue_byte(8'h3F, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b0);

    // empty stream
    set_stream_length(32'd0);
    queue_byte(8'hAB, 1'b1);

    random_done = 0;
    phase_no = 0;
    while (random_done < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       limit = 32'hFFFF_FFFF;
        1:       limit = 32'd0;
        2:       limit = $urandom_range(1, 3);
        3:       limit = $urandom_range(4, 16);
        4:       limit = $urandom_range(17, 80);
        5:       limit = $urandom_range(81, 400);
        default: limit = $urandom() | 32'h8000_0000;
      endcase
      set_stream_length(limit);
      phase_bytes = 0;
      streams = 0;
      while (phase_bytes < 150 && streams < 20) begin
        if (limit == 0)
          span = $urandom_range(1, 4);
        else if (limit <= 400)
          span = limit + $urandom_range(0, 3);
        else
          span = $urandom_range(10, 300);
        build_stream(span, streams > 0 || $urandom_range(0, 3) != 0,
                     $urandom_range(0, 9) == 0);
        phase_bytes += (span < limit) ? span : limit;
        streams++;
        // hold the sender until every result is back
        if (phase_no == 2 && streams == 3) wait_drained();
      end
      random_done += phase_bytes;
      phase_no++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && deframed_due.size() == 0)
      $display("PASS swf_tag_record_deframer");
    else
      $display("FAIL swf_tag_record_deframer");
    $finish;
  end

endmodule
